// File: hw/rtl/i2cms_pkg.sv
// Shared types and constants for the I2C master transfer sequencer.
// Used by every module of the block; depends on nothing else.

package i2cms_pkg;

  localparam int unsigned MAX_TRANSFER_DEF = 4096;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned COUNT_W    = 13;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUB_ADDRESS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_FORMAT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_READ_NOT_WRITE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_COUNT     = 3'd4;

  // Input opcodes.
  localparam logic OP_START  = 1'b0;
  localparam logic OP_STATUS = 1'b1;

  // Master status codes with the low three bits masked off.
  localparam logic [7:0] ST_MASK        = 8'hF8;
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RESTART     = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
  localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
  localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST    = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
  localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
  localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

  // Control register bits.
  localparam logic [6:0] CTL_ACK   = 7'h04;
  localparam logic [6:0] CTL_SI    = 7'h08;
  localparam logic [6:0] CTL_STOP  = 7'h10;
  localparam logic [6:0] CTL_START = 7'h20;
  localparam logic [6:0] CTL_EN    = 7'h40;

  // Address formats.
  localparam logic [1:0] FMT_NONE   = 2'd0;
  localparam logic [1:0] FMT_ONE    = 2'd1;
  localparam logic [1:0] FMT_TWO    = 2'd2;
  localparam logic [1:0] FMT_EIGHTX = 2'd3;

  // Sub-address phase.
  localparam logic [1:0] PH_NONE  = 2'd0;
  localparam logic [1:0] PH_READ  = 2'd1;
  localparam logic [1:0] PH_WRITE = 2'd2;

  // Finish codes.
  localparam logic [1:0] FIN_BUSY = 2'd0;
  localparam logic [1:0] FIN_OK   = 2'd1;
  localparam logic [1:0] FIN_FAIL = 2'd2;

  typedef struct packed {
    logic [7:0]         device_address;
    logic [15:0]        sub_address;
    logic [1:0]         address_format;
    logic               read_not_write;
    logic [COUNT_W-1:0] byte_count;
  } cfg_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] bus_status;
    logic [7:0] rx_data;
    logic [7:0] tx_data;
  } item_t;

  typedef struct packed {
    logic       load_data;
    logic [7:0] data_to_send;
    logic       took_tx_byte;
    logic [6:0] control_set;
    logic [6:0] control_clear;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [1:0] done_status;
  } result_t;

endpackage

// File: hw/rtl/i2cms_cfg.sv
// Configuration register file of the I2C master transfer sequencer.
// Depends on i2cms_pkg for the register indexes and the cfg_t type.

module i2cms_cfg import i2cms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address <= '0;
      cfg_r.sub_address    <= '0;
      cfg_r.address_format <= '0;
      cfg_r.read_not_write <= 1'b0;
      cfg_r.byte_count     <= COUNT_W'(1);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEVICE_ADDRESS: cfg_r.device_address <= wr_data[7:0];
        REG_SUB_ADDRESS:    cfg_r.sub_address    <= wr_data[15:0];
        REG_ADDRESS_FORMAT: cfg_r.address_format <= wr_data[1:0];
        REG_READ_NOT_WRITE: cfg_r.read_not_write <= wr_data[0];
        REG_BYTE_COUNT:     cfg_r.byte_count     <= wr_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hw/rtl/i2cms_seq.sv
// Transfer state and status decode of the I2C master transfer sequencer.
// Depends on i2cms_pkg; the state advances on each word that fire marks.

module i2cms_seq import i2cms_pkg::*; #(
  parameter int unsigned MAX_TRANSFER = MAX_TRANSFER_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  logic [7:0]         address_byte_r, address_byte_nxt;
  logic [15:0]        sub_value_r, sub_value_nxt;
  logic [1:0]         sub_left_r, sub_left_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [COUNT_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [1:0]         finish_r, finish_nxt;

  logic [7:0]         st;
  logic [7:0]         addr_sum;
  logic [COUNT_W-1:0] start_cnt;
  logic [COUNT_W-1:0] rx_left;
  logic [6:0]         ack_set, ack_clr;

  assign st = item.bus_status & ST_MASK;

  assign addr_sum = cfg.device_address
                  + ((cfg.address_format == FMT_EIGHTX) ?
                     {4'b0, cfg.sub_address[10:8], 1'b0} : 8'd0)
                  + {7'b0, cfg.read_not_write};

  assign start_cnt = ({{(32-COUNT_W){1'b0}}, cfg.byte_count} > 32'(MAX_TRANSFER)) ?
                     COUNT_W'(MAX_TRANSFER) : cfg.byte_count;

  assign rx_left = (bytes_left_r != '0) ? bytes_left_r - COUNT_W'(1) : bytes_left_r;

  always_comb begin
    address_byte_nxt = address_byte_r;
    sub_value_nxt    = sub_value_r;
    sub_left_nxt     = sub_left_r;
    phase_nxt        = phase_r;
    bytes_left_nxt   = bytes_left_r;
    finish_nxt       = finish_r;
    res              = '0;
    ack_set          = '0;
    ack_clr          = '0;

    if (item.opcode == OP_START) begin
      if (cfg.byte_count == '0) begin
        finish_nxt = FIN_FAIL;
      end else begin
        address_byte_nxt = addr_sum;
        if (cfg.address_format == FMT_EIGHTX) begin
          sub_value_nxt = {8'd0, cfg.sub_address[7:0]};
          sub_left_nxt  = 2'd1;
        end else begin
          sub_value_nxt = cfg.sub_address;
          sub_left_nxt  = cfg.address_format;
        end
        phase_nxt         = (cfg.address_format == FMT_NONE) ? PH_NONE :
                            (cfg.read_not_write ? PH_READ : PH_WRITE);
        bytes_left_nxt    = start_cnt;
        finish_nxt        = FIN_BUSY;
        res.control_clear = CTL_ACK | CTL_SI | CTL_START;
        res.control_set   = CTL_START | CTL_EN;
      end
    end else begin
      unique case (st)
        ST_START: begin
          res.load_data     = 1'b1;
          res.data_to_send  = (phase_r == PH_READ) ? (address_byte_r & 8'hFE)
                                                   : address_byte_r;
          res.control_clear = CTL_SI | CTL_START;
        end
        ST_RESTART: begin
          res.load_data     = 1'b1;
          res.data_to_send  = address_byte_r;
          res.control_clear = CTL_SI | CTL_START;
        end
        ST_SLA_W_ACK, ST_DATA_W_ACK: begin
          if (phase_r == PH_NONE) begin
            res.control_clear = CTL_SI | CTL_START;
            if (bytes_left_r != '0) begin
              res.load_data    = 1'b1;
              res.data_to_send = item.tx_data;
              res.took_tx_byte = 1'b1;
              bytes_left_nxt   = bytes_left_r - COUNT_W'(1);
            end else begin
              res.control_set = CTL_STOP;
              finish_nxt      = FIN_OK;
            end
          end else if (phase_r == PH_READ || phase_r == PH_WRITE) begin
            if (sub_left_r[1]) begin
              res.load_data     = 1'b1;
              res.data_to_send  = sub_value_r[15:8];
              res.control_clear = CTL_SI | CTL_START;
              sub_left_nxt      = 2'd1;
            end else if (sub_left_r[0]) begin
              res.load_data     = 1'b1;
              res.data_to_send  = sub_value_r[7:0];
              res.control_clear = CTL_SI | CTL_START;
              sub_left_nxt      = 2'd0;
              if (phase_r == PH_WRITE) phase_nxt = PH_NONE;
            end else if (phase_r == PH_READ) begin
              res.control_clear = CTL_SI;
              res.control_set   = CTL_START;
              phase_nxt         = PH_NONE;
            end
          end
        end
        ST_SLA_R_ACK: begin
          if (bytes_left_r <= COUNT_W'(1)) begin
            res.control_clear = CTL_ACK | CTL_SI | CTL_START;
          end else begin
            res.control_set   = CTL_ACK;
            res.control_clear = CTL_SI | CTL_START;
          end
        end
        ST_SLA_W_NACK, ST_DATA_W_NACK, ST_ARB_LOST, ST_SLA_R_NACK: begin
          res.control_clear = CTL_SI | CTL_START;
          finish_nxt        = FIN_FAIL;
        end
        ST_DATA_R_ACK: begin
          res.read_valid = 1'b1;
          res.read_byte  = item.rx_data;
          bytes_left_nxt = rx_left;
          if (rx_left <= COUNT_W'(1)) begin
            res.control_clear = CTL_ACK | CTL_SI | CTL_START;
          end else begin
            res.control_set   = CTL_ACK;
            res.control_clear = CTL_SI | CTL_START;
          end
        end
        ST_DATA_R_NACK: begin
          res.read_valid    = 1'b1;
          res.read_byte     = item.rx_data;
          res.control_set   = CTL_STOP;
          res.control_clear = CTL_SI | CTL_START;
          finish_nxt        = FIN_OK;
        end
        default: begin
          ack_set = '0;
          ack_clr = '0;
        end
      endcase
    end
    res.done_status = finish_nxt;
    res.control_set   = res.control_set | ack_set;
    res.control_clear = res.control_clear | ack_clr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      address_byte_r <= '0;
      sub_value_r    <= '0;
      sub_left_r     <= '0;
      phase_r        <= PH_NONE;
      bytes_left_r   <= '0;
      finish_r       <= FIN_BUSY;
    end else if (fire) begin
      address_byte_r <= address_byte_nxt;
      sub_value_r    <= sub_value_nxt;
      sub_left_r     <= sub_left_nxt;
      phase_r        <= phase_nxt;
      bytes_left_r   <= bytes_left_nxt;
      finish_r       <= finish_nxt;
    end
  end

endmodule

// File: hw/rtl/i2c_master_transfer_sequencer.sv
// I2C master transfer sequencer: input register, decode, result register.
// An accepted word is decoded from the input register, and its result word is held in the result register on out_*.
// Throughput is one word per cycle while out_stall is low; the status decode is combinational.
// Synchronous active-low reset clears both register stages and all transfer
// state; configuration resets to zero except byte_count, which resets to one.
// Depends on i2cms_pkg, i2cms_cfg and i2cms_seq.

module i2c_master_transfer_sequencer import i2cms_pkg::*; #(
  parameter int unsigned MAX_TRANSFER = MAX_TRANSFER_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_opcode,
  input  logic [7:0]            in_bus_status,
  input  logic [7:0]            in_rx_data,
  input  logic [7:0]            in_tx_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_load_data,
  output logic [7:0]            out_data_to_send,
  output logic                  out_took_tx_byte,
  output logic [6:0]            out_control_set,
  output logic [6:0]            out_control_clear,
  output logic                  out_read_valid,
  output logic [7:0]            out_read_byte,
  output logic [1:0]            out_done_status
);

  cfg_t    cfg;
  item_t   item_r;
  logic    item_valid_r;
  result_t res;
  result_t res_r;
  logic    res_valid_r;
  logic    advance;
  logic    in_fire;

  assign cfg_ready = 1'b1;

  i2cms_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign advance  = !res_valid_r || !out_stall;
  assign in_stall = item_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (advance || !item_valid_r) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.opcode     <= in_opcode;
      item_r.bus_status <= in_bus_status;
      item_r.rx_data    <= in_rx_data;
      item_r.tx_data    <= in_tx_data;
    end
  end

  i2cms_seq #(
    .MAX_TRANSFER (MAX_TRANSFER)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (item_valid_r && advance),
    .item  (item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid_r) begin
      res_r <= res;
    end
  end

  assign out_valid         = res_valid_r;
  assign out_load_data     = res_r.load_data;
  assign out_data_to_send  = res_r.data_to_send;
  assign out_took_tx_byte  = res_r.took_tx_byte;
  assign out_control_set   = res_r.control_set;
  assign out_control_clear = res_r.control_clear;
  assign out_read_valid    = res_r.read_valid;
  assign out_read_byte     = res_r.read_byte;
  assign out_done_status   = res_r.done_status;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (item_valid_r && res_valid_r && out_stall))
    else $error("input stalled while the pipeline can move");

  a_took_implies_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_took_tx_byte) |-> out_load_data)
    else $error("write byte taken without a data load");

  a_no_load_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_load_data) |-> (out_data_to_send == 8'd0))
    else $error("data word present without a load");

  a_read_excludes_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_read_valid) |-> (!out_load_data && out_done_status != 2'd3))
    else $error("receive word combined with a load or a bad finish code");

  a_held_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(out_valid && out_stall) && $past(rst_n)) |-> (out_valid && $stable(res_r)))
    else $error("stalled result word changed");

endmodule

// File: test/tb.sv
// Self-checking testbench for i2c_master_transfer_sequencer.
// Queued words are driven and results are checked against a built-in predictor.
// Depends on i2cms_pkg and the sequencer RTL only.
`timescale 1ns / 100ps

module tb;
  import i2cms_pkg::*;

  localparam logic [7:0] ST_UNKNOWN_LO = 8'h00;
  localparam logic [7:0] ST_UNKNOWN_HI = 8'hF8;
  localparam int unsigned WORDS_WANTED = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  item_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  result_t seen;

  item_t words_to_send[$];
  result_t due_results[$];
  int words_queued = 0;
  int errors = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  logic rx_hold = 1'b0;

  cfg_t shadow_cfg;
  logic [7:0] tr_addr;
  logic [15:0] tr_sub;
  logic [1:0] tr_sub_left;
  logic [1:0] tr_phase;
  logic [COUNT_W-1:0] tr_left;
  logic [1:0] tr_finish;

  i2c_master_transfer_sequencer u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_word.opcode),
    .in_bus_status(in_word.bus_status),
    .in_rx_data(in_word.rx_data),
    .in_tx_data(in_word.tx_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_load_data(seen.load_data),
    .out_data_to_send(seen.data_to_send),
    .out_took_tx_byte(seen.took_tx_byte),
    .out_control_set(seen.control_set),
    .out_control_clear(seen.control_clear),
    .out_read_valid(seen.read_valid),
    .out_read_byte(seen.read_byte),
    .out_done_status(seen.done_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic result_t step_sequencer(input item_t w);
    result_t r;
    logic [7:0] st;
    logic [7:0] a;
    r = '0;
    st = w.bus_status & ST_MASK;
    if (w.opcode == OP_START) begin
      if (shadow_cfg.byte_count == '0) begin
        tr_finish = FIN_FAIL;
      end else begin
        a = shadow_cfg.device_address;
        if (shadow_cfg.address_format == FMT_EIGHTX) begin
          a = a + {4'h0, shadow_cfg.sub_address[10:8], 1'b0};
          tr_sub = {8'h00, shadow_cfg.sub_address[7:0]};
          tr_sub_left = 2'd1;
        end else begin
          tr_sub = shadow_cfg.sub_address;
          tr_sub_left = shadow_cfg.address_format;
        end
        if (shadow_cfg.read_not_write) a = a + 8'd1;
        tr_addr = a;
        if (shadow_cfg.address_format == FMT_NONE) tr_phase = PH_NONE;
        else tr_phase = shadow_cfg.read_not_write ? PH_READ : PH_WRITE;
        tr_left = (shadow_cfg.byte_count > COUNT_W'(MAX_TRANSFER_DEF)) ?
                  COUNT_W'(MAX_TRANSFER_DEF) : shadow_cfg.byte_count;
        tr_finish = FIN_BUSY;
        r.control_clear = CTL_ACK | CTL_SI | CTL_START;
        r.control_set = CTL_START | CTL_EN;
      end
    end else begin
      case (st)
        ST_START: begin
          r.load_data = 1'b1;
          r.data_to_send = (tr_phase == PH_READ) ? {tr_addr[7:1], 1'b0} : tr_addr;
          r.control_clear = CTL_SI | CTL_START;
        end
        ST_RESTART: begin
          r.load_data = 1'b1;
          r.data_to_send = tr_addr;
          r.control_clear = CTL_SI | CTL_START;
        end
        ST_SLA_W_ACK, ST_DATA_W_ACK: begin
          if (tr_phase == PH_NONE) begin
            r.control_clear = CTL_SI | CTL_START;
            if (tr_left > 0) begin
              r.load_data = 1'b1;
              r.data_to_send = w.tx_data;
              r.took_tx_byte = 1'b1;
              tr_left = tr_left - COUNT_W'(1);
            end else begin
              r.control_set = CTL_STOP;
              tr_finish = FIN_OK;
            end
          end else if (tr_phase == PH_READ || tr_phase == PH_WRITE) begin
            if (tr_sub_left >= 2) begin
              r.load_data = 1'b1;
              r.data_to_send = tr_sub[15:8];
              r.control_clear = CTL_SI | CTL_START;
              tr_sub_left = 2'd1;
            end else if (tr_sub_left == 1) begin
              r.load_data = 1'b1;
              r.data_to_send = tr_sub[7:0];
              r.control_clear = CTL_SI | CTL_START;
              tr_sub_left = 2'd0;
              if (tr_phase == PH_WRITE) tr_phase = PH_NONE;
            end else if (tr_phase == PH_READ) begin
              r.control_clear = CTL_SI;
              r.control_set = CTL_START;
              tr_phase = PH_NONE;
            end
          end
        end
        ST_SLA_R_ACK, ST_DATA_R_ACK: begin
          if (st == ST_DATA_R_ACK) begin
            r.read_valid = 1'b1;
            r.read_byte = w.rx_data;
            if (tr_left > 0) tr_left = tr_left - COUNT_W'(1);
          end
          if (tr_left <= 1) begin
            r.control_clear = CTL_ACK | CTL_SI | CTL_START;
          end else begin
            r.control_set = CTL_ACK;
            r.control_clear = CTL_SI | CTL_START;
          end
        end
        ST_SLA_W_NACK, ST_DATA_W_NACK, ST_ARB_LOST, ST_SLA_R_NACK: begin
          r.control_clear = CTL_SI | CTL_START;
          tr_finish = FIN_FAIL;
        end
        ST_DATA_R_NACK: begin
          r.read_valid = 1'b1;
          r.read_byte = w.rx_data;
          r.control_set = CTL_STOP;
          r.control_clear = CTL_SI | CTL_START;
          tr_finish = FIN_OK;
        end
        default: begin
        end
      endcase
    end
    r.done_status = tr_finish;
    return r;
  endfunction

  function automatic void compare_field(input string name, input int unsigned want_v,
                                        input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) due_results.push_back(step_sequencer(in_word));
      if (!in_valid || !in_stall) begin
        if (words_to_send.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_word <= words_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %h", $time, seen);
          errors++;
        end else begin
          want = due_results.pop_front();
          compare_field("load_data", want.load_data, seen.load_data);
          compare_field("data_to_send", want.data_to_send, seen.data_to_send);
          compare_field("took_tx_byte", want.took_tx_byte, seen.took_tx_byte);
          compare_field("control_set", want.control_set, seen.control_set);
          compare_field("control_clear", want.control_clear, seen.control_clear);
          compare_field("read_valid", want.read_valid, seen.read_valid);
          compare_field("read_byte", want.read_byte, seen.read_byte);
          compare_field("done_status", want.done_status, seen.done_status);
        end
      end
      out_stall <= rx_hold || ($urandom_range(99) < receiver_stall_pct);
    end
  end

  function automatic void queue_word(input logic op, input logic [7:0] st);
    item_t w;
    w.opcode = op;
    w.bus_status = st;
    w.rx_data = 8'($urandom);
    w.tx_data = 8'($urandom);
    words_to_send.push_back(w);
    words_queued++;
  endfunction

  function automatic void queue_status(input logic [7:0] code);
    queue_word(OP_STATUS, code | 8'($urandom_range(7)));
  endfunction

  function automatic void queue_start();
    queue_word(OP_START, 8'($urandom));
  endfunction

  // One transfer as the bus would report it, sometimes cut short by a failure
  // code and sprinkled with stray words.
  function automatic void queue_transfer();
    logic [7:0] codes[$];
    logic [7:0] fails[4];
    int nsub;
    int ndata;
    int cut;
    fails = '{ST_SLA_W_NACK, ST_DATA_W_NACK, ST_ARB_LOST, ST_SLA_R_NACK};
    nsub = (shadow_cfg.address_format == FMT_EIGHTX) ? 1 : int'(shadow_cfg.address_format);
    ndata = (shadow_cfg.byte_count > 32) ? 32 : int'(shadow_cfg.byte_count);
    codes.push_back(ST_START);
    if (shadow_cfg.read_not_write) begin
      if (nsub > 0) begin
        codes.push_back(ST_SLA_W_ACK);
        repeat (nsub) codes.push_back(ST_DATA_W_ACK);
        codes.push_back(ST_RESTART);
      end
      codes.push_back(ST_SLA_R_ACK);
      repeat (ndata - 1) codes.push_back(ST_DATA_R_ACK);
      codes.push_back(ST_DATA_R_NACK);
    end else begin
      codes.push_back(ST_SLA_W_ACK);
      repeat (nsub + ndata) codes.push_back(ST_DATA_W_ACK);
    end
    if ($urandom_range(99) < 15) begin
      cut = $urandom_range(codes.size() - 1);
      while (codes.size() > cut) void'(codes.pop_back());
      codes.push_back(fails[$urandom_range(3)]);
    end
    queue_start();
    foreach (codes[i]) begin
      if ($urandom_range(99) < 3) queue_word(1'($urandom), 8'($urandom));
      queue_status(codes[i]);
    end
  endfunction

  task automatic set_config(input logic [15:0] dev, input logic [15:0] sub,
                            input logic [15:0] fmt, input logic [15:0] rd,
                            input logic [15:0] cnt);
    logic [15:0] vals[5];
    logic [CFG_IDX_W-1:0] regs[5];
    vals = '{dev, sub, fmt, rd, cnt};
    regs = '{REG_DEVICE_ADDRESS, REG_SUB_ADDRESS, REG_ADDRESS_FORMAT,
             REG_READ_NOT_WRITE, REG_BYTE_COUNT};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (regs[i])
        REG_DEVICE_ADDRESS: shadow_cfg.device_address = vals[i][7:0];
        REG_SUB_ADDRESS: shadow_cfg.sub_address = vals[i];
        REG_ADDRESS_FORMAT: shadow_cfg.address_format = vals[i][1:0];
        REG_READ_NOT_WRITE: shadow_cfg.read_not_write = vals[i][0];
        REG_BYTE_COUNT: shadow_cfg.byte_count = vals[i][COUNT_W-1:0];
        default: begin
        end
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Upper bits beyond a register's width are sometimes set to check masking.
  task automatic random_config();
    logic [COUNT_W-1:0] cnt;
    logic [15:0] junk;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) cnt = COUNT_W'($urandom_range(1, 6));
    else if (pick < 90) cnt = COUNT_W'($urandom_range(7, 30));
    else if (pick < 95) cnt = '0;
    else cnt = COUNT_W'($urandom_range(MAX_TRANSFER_DEF, 8191));
    junk = ($urandom_range(3) == 0) ? 16'($urandom) : 16'h0000;
    set_config({junk[15:8], 8'($urandom)}, 16'($urandom),
               {junk[15:2], 2'($urandom)}, {junk[15:1], 1'($urandom)},
               {junk[15:COUNT_W], cnt});
  endtask

  task automatic drain();
    while (words_to_send.size() > 0 || in_valid || due_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int phase_no;
    shadow_cfg = '0;
    shadow_cfg.byte_count = COUNT_W'(1);
    tr_addr = '0;
    tr_sub = '0;
    tr_sub_left = '0;
    tr_phase = PH_NONE;
    tr_left = '0;
    tr_finish = FIN_BUSY;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Address wraps past 8 bits, the count saturates, and a start aborts a
    // transfer in flight.
    set_config(16'h00FF, 16'hFFFF, 16'(FMT_EIGHTX), 16'h0001, 16'h1FFF);
    queue_start();
    queue_status(ST_START);
    queue_start();
    queue_status(ST_START);
    queue_status(ST_SLA_W_ACK);
    queue_status(ST_DATA_W_ACK);
    queue_status(ST_RESTART);
    queue_status(ST_SLA_R_ACK);
    queue_status(ST_DATA_R_ACK);
    queue_status(ST_DATA_R_NACK);
    drain();

    // Plain one-byte write, then events after the finish, a read byte with
    // nothing left, unknown codes and every failure code.
    set_config(16'h0000, 16'h0000, 16'(FMT_NONE), 16'h0000, 16'h0001);
    queue_start();
    queue_status(ST_START);
    queue_status(ST_SLA_W_ACK);
    queue_status(ST_DATA_W_ACK);
    queue_status(ST_DATA_W_ACK);
    queue_status(ST_DATA_R_ACK);
    queue_status(ST_UNKNOWN_LO);
    queue_status(ST_UNKNOWN_HI);
    queue_status(ST_SLA_W_NACK);
    queue_status(ST_DATA_W_NACK);
    queue_status(ST_ARB_LOST);
    queue_status(ST_SLA_R_NACK);
    drain();

    // A start with a zero count fails without touching the transfer.
    set_config(16'h00A4, 16'h1234, 16'(FMT_TWO), 16'h0000, 16'h0000);
    queue_start();
    queue_status(ST_DATA_W_ACK);
    drain();

    phase_no = 0;
    while (words_queued < WORDS_WANTED) begin
      random_config();
      case (phase_no % 4)
        0: begin
          sender_idle_pct <= 0;
          receiver_stall_pct <= 0;
        end
        1: begin
          sender_idle_pct <= 80;
          receiver_stall_pct <= 0;
        end
        2: begin
          sender_idle_pct <= 0;
          receiver_stall_pct <= 80;
        end
        default: begin
          sender_idle_pct <= 22;
          receiver_stall_pct <= 22;
        end
      endcase
      if (phase_no == 5) begin
        sender_idle_pct <= 0;
        receiver_stall_pct <= 0;
        fork
          begin
            rx_hold <= 1'b1;
            repeat (300) @(posedge clk);
            rx_hold <= 1'b0;
          end
        join_none
      end
      repeat (3) queue_transfer();
      drain();
      phase_no++;
    end

    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
